FILE: src/jisenc_pkg.sv
// ----------------------------------------------------------------------------
// jisenc_pkg: shared types and constants for the JIS byte encoder
// Coding modes, register indexes, escape bytes and the per-character plan.
// ----------------------------------------------------------------------------
`default_nettype none

package jisenc_pkg;

  localparam int unsigned MaxBytes = 8;              // worst case: ESC seq + pair + ESC seq
  localparam int unsigned IdxW     = $clog2(MaxBytes);
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  localparam logic [7:0] EscByte       = 8'h1B;
  localparam logic [7:0] Ss2Byte       = 8'h8E;
  localparam logic [7:0] DesigAscii    = 8'h28;      // '('
  localparam logic [7:0] DesigKanji    = 8'h24;      // '$'
  localparam logic [7:0] FinalByteRst  = 8'h42;      // 'B'

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_EUC  = 2'd1,
    MODE_SJIS = 2'd2,
    MODE_ISO  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE     = 2'd0,
    REG_ASCII_FB = 2'd1,
    REG_KANJI_FB = 2'd2
  } cfg_reg_e;

  // Byte sequence for one character, byte 0 goes out first.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
  } plan_t;

endpackage

`default_nettype wire

FILE: src/jisenc_encoder.sv
// ----------------------------------------------------------------------------
// jisenc_encoder: character code to byte sequence
// Builds the full output byte list for one character and the next shift state.
// ----------------------------------------------------------------------------
`default_nettype none

module jisenc_encoder (
  input  wire logic [15:0]          char_code_i,
  input  wire logic                 last_char_i,
  input  jisenc_pkg::mode_e         mode_i,
  input  wire logic [7:0]           ascii_fb_i,
  input  wire logic [7:0]           kanji_fb_i,
  input  wire logic                 shift_i,
  output jisenc_pkg::plan_t         plan_o,
  output logic                      shift_o
);

  logic [7:0] hi;
  logic [7:0] lo;
  logic       is_ascii;
  logic       is_single;
  logic [7:0] sjis_lead;
  logic [7:0] sjis_trail;

  assign hi        = char_code_i[15:8];
  assign lo        = char_code_i[7:0];
  assign is_single = (hi == 8'h00);
  assign is_ascii  = is_single && !lo[7];

  // JIS row/cell to Shift_JIS, results wrap to 8 bits; (hi + 1) >> 1 as hi/2 + hi[0]
  assign sjis_lead = {1'b0, hi[7:1]} + {7'b0, hi[0]} + ((hi <= 8'h5E) ? 8'h70 : 8'hB0);

  always_comb begin
    if (hi[0]) begin
      sjis_trail = lo + ((lo >= 8'h60) ? 8'h20 : 8'h1F);
    end else begin
      sjis_trail = lo + 8'h7E;
    end
  end

  always_comb begin
    logic [jisenc_pkg::CntW-1:0] n;
    logic                        sh;
    plan_o.bytes = '0;
    n            = '0;
    sh           = shift_i;
    unique case (mode_i)
      jisenc_pkg::MODE_EUC: begin
        if (is_ascii) begin
          plan_o.bytes[0] = lo;
          n               = jisenc_pkg::CntW'(1);
        end else if (is_single) begin
          plan_o.bytes[0] = jisenc_pkg::Ss2Byte;
          plan_o.bytes[1] = {1'b0, lo[6:0]};
          n               = jisenc_pkg::CntW'(2);
        end else begin
          plan_o.bytes[0] = hi | 8'h80;
          plan_o.bytes[1] = lo | 8'h80;
          n               = jisenc_pkg::CntW'(2);
        end
        if (last_char_i) sh = 1'b0;
      end
      jisenc_pkg::MODE_SJIS: begin
        if (is_single) begin
          plan_o.bytes[0] = lo;
          n               = jisenc_pkg::CntW'(1);
        end else begin
          plan_o.bytes[0] = sjis_lead;
          plan_o.bytes[1] = sjis_trail;
          n               = jisenc_pkg::CntW'(2);
        end
        if (last_char_i) sh = 1'b0;
      end
      jisenc_pkg::MODE_ISO: begin
        if (is_single) begin
          if (sh) begin
            plan_o.bytes[0] = jisenc_pkg::EscByte;
            plan_o.bytes[1] = jisenc_pkg::DesigAscii;
            plan_o.bytes[2] = ascii_fb_i;
            n               = jisenc_pkg::CntW'(3);
            sh              = 1'b0;
          end
          plan_o.bytes[n[jisenc_pkg::IdxW-1:0]] = lo;
          n = n + jisenc_pkg::CntW'(1);
        end else begin
          if (!sh) begin
            plan_o.bytes[0] = jisenc_pkg::EscByte;
            plan_o.bytes[1] = jisenc_pkg::DesigKanji;
            plan_o.bytes[2] = kanji_fb_i;
            n               = jisenc_pkg::CntW'(3);
            sh              = 1'b1;
          end
          plan_o.bytes[n[jisenc_pkg::IdxW-1:0]] = hi;
          n = n + jisenc_pkg::CntW'(1);
          plan_o.bytes[n[jisenc_pkg::IdxW-1:0]] = lo;
          n = n + jisenc_pkg::CntW'(1);
        end
        // end of string: fall back to ASCII
        if (last_char_i && sh) begin
          plan_o.bytes[n[jisenc_pkg::IdxW-1:0]] = jisenc_pkg::EscByte;
          n = n + jisenc_pkg::CntW'(1);
          plan_o.bytes[n[jisenc_pkg::IdxW-1:0]] = jisenc_pkg::DesigAscii;
          n = n + jisenc_pkg::CntW'(1);
          plan_o.bytes[n[jisenc_pkg::IdxW-1:0]] = ascii_fb_i;
          n = n + jisenc_pkg::CntW'(1);
          sh = 1'b0;
        end
      end
      default: begin
        plan_o.bytes[0] = lo;
        n               = jisenc_pkg::CntW'(1);
        if (last_char_i) sh = 1'b0;
      end
    endcase
    plan_o.cnt = n;
    shift_o    = sh;
  end

endmodule

`default_nettype wire

FILE: src/jis_multi_encoding_byte_encoder.sv
// ----------------------------------------------------------------------------
// jis_multi_encoding_byte_encoder: JIS character stream to encoded bytes
// Pass-through, EUC-JP, Shift_JIS or ISO-2022-JP, one output byte per beat.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata=char_code, tlast=last_char
// m_axis    out  m_axis_tvalid/tready       tdata=out_byte, tlast=run_end
// cfg       in   cfg_valid_i/cfg_ready_o    cfg_addr_i=register, cfg_data_i
//
// A character is encoded in the cycle it is accepted into a byte buffer of up
// to 8 bytes (usually 1 or 2); the buffer drains one byte per cycle into the
// output register unless the output stalls. The next character is taken in
// the cycle its predecessor's last byte moves out, so output stalls hold the
// buffer and input. Reset clears the buffer, output valid, shift state and
// registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module jis_multi_encoding_byte_encoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [7:0]  cfg_data_i,
  // character input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] char_code
  input  wire logic        s_axis_tlast,   // last_char
  // byte output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast    // run_end
);

  jisenc_pkg::mode_e mode_q;
  logic [7:0]        ascii_fb_q;
  logic [7:0]        kanji_fb_q;
  logic              shift_q, shift_d;

  jisenc_pkg::plan_t plan_d;
  jisenc_pkg::plan_t job_q;
  logic              job_valid_q;
  logic [jisenc_pkg::IdxW-1:0] idx_q;

  logic              s_beat;
  logic              out_free;
  logic              move;
  logic              job_last;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= jisenc_pkg::MODE_PASS;
      ascii_fb_q <= jisenc_pkg::FinalByteRst;
      kanji_fb_q <= jisenc_pkg::FinalByteRst;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        jisenc_pkg::REG_MODE:     mode_q     <= jisenc_pkg::mode_e'(cfg_data_i[1:0]);
        jisenc_pkg::REG_ASCII_FB: ascii_fb_q <= cfg_data_i;
        jisenc_pkg::REG_KANJI_FB: kanji_fb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  jisenc_encoder u_enc (
    .char_code_i (s_axis_tdata),
    .last_char_i (s_axis_tlast),
    .mode_i      (mode_q),
    .ascii_fb_i  (ascii_fb_q),
    .kanji_fb_i  (kanji_fb_q),
    .shift_i     (shift_q),
    .plan_o      (plan_d),
    .shift_o     (shift_d)
  );

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign move          = job_valid_q && out_free;
  assign job_last      = ({1'b0, idx_q} + jisenc_pkg::CntW'(1)) == job_q.cnt;
  assign s_axis_tready = !job_valid_q || (move && job_last);
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= 1'b0;
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (s_beat) begin
        shift_q     <= shift_d;
        job_valid_q <= 1'b1;
        idx_q       <= '0;
      end else if (move) begin
        if (job_last) job_valid_q <= 1'b0;
        idx_q <= idx_q + jisenc_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) job_q <= plan_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      m_axis_tdata <= job_q.bytes[idx_q];
      m_axis_tlast <= job_last;
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_q.cnt != '0) && (job_q.cnt <= jisenc_pkg::CntW'(jisenc_pkg::MaxBytes)))
    else $error("byte buffer count out of range");

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> ({1'b0, idx_q} < job_q.cnt))
    else $error("byte index past end of buffer");

  a_no_early_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && !(move && job_last)) |-> !s_axis_tready)
    else $error("input taken while bytes remain");

  a_shift_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_beat && s_axis_tlast) |=> !shift_q)
    else $error("shift state left set after last character");
`endif

endmodule

`default_nettype wire

FILE: test/jis_multi_encoding_byte_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jis_multi_encoding_byte_encoder_tb: self-checking bench for the JIS encoder
// Directed cases for each coding mode and the ISO-2022-JP shift handling,
// then random strings under random configs. A predictor built from the
// register copies expands each accepted character into its byte sequence;
// every output beat is checked against the oldest expected byte.
// ----------------------------------------------------------------------------

module jis_multi_encoding_byte_encoder_tb;

  localparam int unsigned StallMax  = 11;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned TailWait  = 20;
  localparam int unsigned RandChars = 130;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
  } enc_beat_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  jisenc_pkg::cfg_reg_e  cfg_addr      = jisenc_pkg::REG_MODE;
  logic [7:0]            cfg_data      = 8'h00;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = 16'h0000;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;

  // predictor copy of the block's registers and shift state
  jisenc_pkg::mode_e     cur_mode;
  logic [7:0]            ascii_fb;
  logic [7:0]            kanji_fb;
  logic                  kanji_shift;

  enc_beat_t   pending_bytes[$];
  int unsigned errors     = 0;
  int unsigned n_chars    = 0;
  int unsigned n_bytes    = 0;
  int unsigned idle_count = 0;
  int unsigned rx_hold    = 0;
  bit          no_idle    = 1'b0;

  jis_multi_encoding_byte_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Expand one character into the bytes the block must emit.
  task automatic encode_char(input logic [15:0] code, input logic is_last);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] lead_b;
    logic [7:0] trail_b;
    logic [7:0] seq[$];
    enc_beat_t  beat;
    hi = code[15:8];
    lo = code[7:0];
    case (cur_mode)
      jisenc_pkg::MODE_EUC: begin
        if (code < 16'h0080) begin
          seq.push_back(lo);
        end else if (code < 16'h0100) begin
          seq.push_back(jisenc_pkg::Ss2Byte);
          seq.push_back({1'b0, lo[6:0]});
        end else begin
          seq.push_back(hi | 8'h80);
          seq.push_back(lo | 8'h80);
        end
        if (is_last) kanji_shift = 1'b0;
      end
      jisenc_pkg::MODE_SJIS: begin
        if (code < 16'h0100) begin
          seq.push_back(lo);
        end else begin
          // 8-bit wraparound gives the masking for out-of-range pairs
          lead_b = {1'b0, hi[7:1]} + {7'b0, hi[0]} + ((hi <= 8'h5E) ? 8'h70 : 8'hB0);
          if (hi[0]) trail_b = lo + ((lo >= 8'h60) ? 8'h20 : 8'h1F);
          else trail_b = lo + 8'h7E;
          seq.push_back(lead_b);
          seq.push_back(trail_b);
        end
        if (is_last) kanji_shift = 1'b0;
      end
      jisenc_pkg::MODE_ISO: begin
        if (code < 16'h0100) begin
          if (kanji_shift) begin
            seq.push_back(jisenc_pkg::EscByte);
            seq.push_back(jisenc_pkg::DesigAscii);
            seq.push_back(ascii_fb);
            kanji_shift = 1'b0;
          end
          seq.push_back(lo);
        end else begin
          if (!kanji_shift) begin
            seq.push_back(jisenc_pkg::EscByte);
            seq.push_back(jisenc_pkg::DesigKanji);
            seq.push_back(kanji_fb);
            kanji_shift = 1'b1;
          end
          seq.push_back(hi);
          seq.push_back(lo);
        end
        if (is_last && kanji_shift) begin
          seq.push_back(jisenc_pkg::EscByte);
          seq.push_back(jisenc_pkg::DesigAscii);
          seq.push_back(ascii_fb);
          kanji_shift = 1'b0;
        end
      end
      default: begin
        seq.push_back(lo);
        if (is_last) kanji_shift = 1'b0;
      end
    endcase
    foreach (seq[i]) begin
      beat.data    = seq[i];
      beat.run_end = (i == seq.size() - 1);
      pending_bytes.push_back(beat);
    end
  endtask

  // Monitor: register writes, accepted characters and output beats.
  always @(posedge clk_i) begin
    enc_beat_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr)
          jisenc_pkg::REG_MODE:     cur_mode = jisenc_pkg::mode_e'(cfg_data[1:0]);
          jisenc_pkg::REG_ASCII_FB: ascii_fb = cfg_data;
          jisenc_pkg::REG_KANJI_FB: kanji_fb = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) encode_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        n_bytes++;
        rx_hold = no_idle ? 0 : $urandom_range(0, StallMax);
        if (pending_bytes.size() == 0) begin
          $error("out_byte: no byte expected, got 0x%02h run_end %0b",
                 m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (m_axis_tdata !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, m_axis_tlast);
            errors++;
          end
        end
      end
    end
  end

  // Output side back-pressure: a random stall after each beat, none while no_idle is set.
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      m_axis_tready = 1'b0;
      rx_hold--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [15:0] code, input logic is_last);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, StallMax);
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = code;
    s_axis_tlast  = is_last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    n_chars++;
  endtask

  // Stop the input stream and let every expected byte come out.
  task automatic drain_stream();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input jisenc_pkg::cfg_reg_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_addr    = idx;
    cfg_data    = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(input jisenc_pkg::mode_e mode, input logic [7:0] afb,
                            input logic [7:0] kfb);
    drain_stream();
    write_reg(jisenc_pkg::REG_MODE, {6'b0, mode});
    write_reg(jisenc_pkg::REG_ASCII_FB, afb);
    write_reg(jisenc_pkg::REG_KANJI_FB, kfb);
  endtask

  // Register defaults: pass-through with no writes at all.
  task automatic test_reset_defaults();
    send_char(16'h0000, 1'b0);
    send_char(16'hFFFF, 1'b1);
  endtask

  task automatic test_pass_through();
    drain_stream();
    write_reg(jisenc_pkg::REG_MODE, {6'b0, jisenc_pkg::MODE_PASS});
    send_char(16'h007F, 1'b0);
    send_char(16'h8080, 1'b1);
  endtask

  task automatic test_euc();
    drain_stream();
    write_reg(jisenc_pkg::REG_MODE, {6'b0, jisenc_pkg::MODE_EUC});
    send_char(16'h007F, 1'b0);
    send_char(16'h0080, 1'b0);
    send_char(16'h00FF, 1'b0);
    send_char(16'h2121, 1'b0);
    send_char(16'hFFFF, 1'b1);
  endtask

  // Both row parities, both trail ranges, the lead split, and out-of-range pairs.
  task automatic test_sjis();
    drain_stream();
    write_reg(jisenc_pkg::REG_MODE, {6'b0, jisenc_pkg::MODE_SJIS});
    send_char(16'h00FF, 1'b0);
    send_char(16'h2121, 1'b0);
    send_char(16'h215F, 1'b0);
    send_char(16'h2160, 1'b0);
    send_char(16'h5E7E, 1'b0);
    send_char(16'h5F21, 1'b0);
    send_char(16'h0100, 1'b1);
  endtask

  task automatic test_iso_escapes();
    drain_stream();
    write_reg(jisenc_pkg::REG_MODE, {6'b0, jisenc_pkg::MODE_ISO});
    // final bytes still at reset value
    send_char(16'h0041, 1'b0);
    send_char(16'h2422, 1'b0);
    send_char(16'h2423, 1'b0);
    send_char(16'h0042, 1'b0);
    send_char(16'h3021, 1'b1);
    set_config(jisenc_pkg::MODE_ISO, 8'h00, 8'hFF);
    send_char(16'h2121, 1'b1);
    set_config(jisenc_pkg::MODE_ISO, 8'hFF, 8'h00);
    send_char(16'h7E7E, 1'b0);
    send_char(16'h0000, 1'b1);
  endtask

  // Shift state survives mode changes and is cleared silently by last_char.
  task automatic test_mode_switch_state();
    set_config(jisenc_pkg::MODE_ISO, jisenc_pkg::FinalByteRst, jisenc_pkg::FinalByteRst);
    send_char(16'h2121, 1'b0);
    drain_stream();
    write_reg(jisenc_pkg::REG_MODE, {6'b0, jisenc_pkg::MODE_EUC});
    send_char(16'h0041, 1'b0);
    drain_stream();
    write_reg(jisenc_pkg::REG_MODE, {6'b0, jisenc_pkg::MODE_ISO});
    send_char(16'h0042, 1'b0);
    send_char(16'h2121, 1'b0);
    drain_stream();
    write_reg(jisenc_pkg::REG_MODE, {6'b0, jisenc_pkg::MODE_SJIS});
    send_char(16'h0030, 1'b1);
    drain_stream();
    write_reg(jisenc_pkg::REG_MODE, {6'b0, jisenc_pkg::MODE_ISO});
    send_char(16'h2121, 1'b1);
  endtask

  task automatic test_random_strings();
    int unsigned sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned str_left;
    int unsigned kind;
    logic [7:0]  afb;
    logic [7:0]  kfb;
    logic [15:0] code;
    logic        is_last;
    sent  = 0;
    phase = 0;
    while (sent < RandChars) begin
      afb = 8'($urandom_range(0, 255));
      kfb = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) afb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 3) == 0) kfb = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      no_idle = (phase == 2);
      // strings may carry over a phase boundary, so the shift state does too
      set_config(jisenc_pkg::mode_e'(2'($urandom_range(0, 3))), afb, kfb);
      phase_len = $urandom_range(10, 30);
      str_left  = $urandom_range(1, 6);
      for (int i = 0; i < phase_len; i++) begin
        kind = $urandom_range(0, 9);
        if (kind < 3) code = 16'($urandom_range(16'h0000, 16'h007F));
        else if (kind == 3) code = 16'($urandom_range(16'h0080, 16'h00FF));
        else if (kind < 8) code = {8'($urandom_range(8'h21, 8'h7E)),
                                   8'($urandom_range(8'h21, 8'h7E))};
        else code = 16'($urandom_range(0, 16'hFFFF));
        str_left--;
        is_last = (str_left == 0);
        if ($urandom_range(0, 9) == 0) is_last = 1'($urandom_range(0, 1));
        if (is_last) str_left = $urandom_range(1, 6);
        send_char(code, is_last);
        sent++;
        if (phase == 1 && i == phase_len / 2) drain_stream();
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    cur_mode    = jisenc_pkg::MODE_PASS;
    ascii_fb    = jisenc_pkg::FinalByteRst;
    kanji_fb    = jisenc_pkg::FinalByteRst;
    kanji_shift = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_pass_through();
    test_euc();
    test_sjis();
    test_iso_escapes();
    test_mode_switch_state();
    test_random_strings();

    drain_stream();
    repeat (TailWait) @(posedge clk_i);
    $display("Sent %0d characters through all four coding modes, checked %0d bytes",
             n_chars, n_bytes);
    $display("including escape insertion, final-byte extremes and shift carry-over");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
